// ===== rtl/otmu_pkg.sv =====
// ----------------------------------------------------------------------------
// otmu_pkg
// Shared types and codes for the owner-tracking mutex unit.
// ----------------------------------------------------------------------------
`default_nettype none

package otmu_pkg;

	localparam int COUNT_BITS   = 16;
	localparam int TID_BITS     = 30;
	localparam int ACTION_BITS  = 3;
	localparam int STATUS_BITS  = 3;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 2;

	typedef logic [TID_BITS-1:0]   tid_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_LOCK       = 3'd0,
		ACT_TRYLOCK    = 3'd1,
		ACT_UNLOCK     = 3'd2,
		ACT_CONSISTENT = 3'd3,
		ACT_DESTROY    = 3'd4,
		ACT_OWNER_DIED = 3'd5
	} action_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK         = 3'd0,
		ST_DEADLOCK   = 3'd1,
		ST_BUSY       = 3'd2,
		ST_NOT_OWNER  = 3'd3,
		ST_OWNER_DEAD = 3'd4,
		ST_INVALID    = 3'd5,
		ST_WAIT       = 3'd6,
		ST_AGAIN      = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		LS_FREE    = 2'd0,
		LS_HELD    = 2'd1,
		LS_WAITERS = 2'd2
	} lock_state_t;

	typedef enum logic [1:0] {
		KIND_NORMAL    = 2'd0,
		KIND_RECURSIVE = 2'd1,
		KIND_ERRCHECK  = 2'd2
	} kind_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_MUTEX_KIND  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROBUST_MODE = 2'd1;

endpackage

`default_nettype wire

// ===== rtl/otmu_if.sv =====
// ----------------------------------------------------------------------------
// otmu_if
// Valid/ready channels of the mutex unit: request, response and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface otmu_req_if;
	logic                                valid;
	logic                                ready;
	logic [otmu_pkg::ACTION_BITS-1:0]    action;
	logic [otmu_pkg::TID_BITS-1:0]       thread_id;

	modport source (output valid, output action, output thread_id, input ready);
	modport sink   (input valid, input action, input thread_id, output ready);
endinterface

interface otmu_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [otmu_pkg::STATUS_BITS-1:0]    status;
	logic                                wake_one;
	logic                                held;
	logic [otmu_pkg::TID_BITS-1:0]       owner_now;

	modport source (output valid, output status, output wake_one, output held,
		output owner_now, input ready);
	modport sink   (input valid, input status, input wake_one, input held,
		input owner_now, output ready);
endinterface

interface otmu_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [otmu_pkg::CFG_IDX_BITS-1:0]   index;
	logic [otmu_pkg::CFG_DAT_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/owner_tracking_mutex_unit.sv =====
// ----------------------------------------------------------------------------
// owner_tracking_mutex_unit
// Single hardware mutex with owner, recursion count and robust recovery.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   action, thread_id
//  rsp      out  valid/ready   status, wake_one, held, owner_now
//  cfg      in   valid/ready   index, data (0 mutex_kind, 1 robust_mode)
//
//  One request per cycle while rsp.ready is high; a response goes out
//  through the input register, then the result register.
//  The decision and the state update happen as a request leaves the input
//  register, so the next request sees the updated state.
//  rsp.ready low holds the result register, then the input register, then
//  req.ready drops. cfg is always ready.
//  Reset clears the lock state, owner, count, flags and config.
// ----------------------------------------------------------------------------
`default_nettype none

module owner_tracking_mutex_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	otmu_req_if.sink           req,
	otmu_rsp_if.source         rsp,
	otmu_cfg_if.sink           cfg
);

	// config
	otmu_pkg::kind_t      kind_q;
	logic                 robust_q;

	// mutex state
	otmu_pkg::lock_state_t lock_state_q, lock_state_d;
	otmu_pkg::tid_t        owner_q, owner_d;
	otmu_pkg::count_t      count_q, count_d;
	logic                  dead_q, dead_d;
	logic                  incons_q, incons_d;

	// input register
	logic                                  valid_s1;
	logic [otmu_pkg::ACTION_BITS-1:0]      act_s1;
	otmu_pkg::tid_t                        tid_s1;

	// result register
	logic                                  valid_s2;
	otmu_pkg::status_t                     status_s2;
	logic                                  wake_s2;
	logic                                  held_s2;
	otmu_pkg::tid_t                        owner_s2;

	otmu_pkg::status_t status_d;
	logic              wake_d;
	logic              adv_s1;
	logic              held;
	logic              own;
	logic              is_try;

	assign cfg.ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= otmu_pkg::KIND_NORMAL;
			robust_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == otmu_pkg::REG_MUTEX_KIND)
				kind_q <= otmu_pkg::kind_t'(cfg.data);
			else if (cfg.index == otmu_pkg::REG_ROBUST_MODE)
				robust_q <= cfg.data[0];
		end
	end

	// decision logic
	assign held   = lock_state_q != otmu_pkg::LS_FREE;
	assign own    = held && (owner_q == tid_s1);
	assign is_try = act_s1 == otmu_pkg::ACT_TRYLOCK;

	always_comb begin
		lock_state_d = lock_state_q;
		owner_d      = owner_q;
		count_d      = count_q;
		dead_d       = dead_q;
		incons_d     = incons_q;
		status_d     = otmu_pkg::ST_INVALID;
		wake_d       = 1'b0;
		unique case (act_s1)
			otmu_pkg::ACT_LOCK, otmu_pkg::ACT_TRYLOCK: begin
				priority if (robust_q && held && dead_q) begin
					// recovery: first caller inherits, waiter mark stays
					owner_d  = tid_s1;
					count_d  = otmu_pkg::count_t'(1);
					dead_d   = 1'b0;
					incons_d = 1'b1;
					status_d = otmu_pkg::ST_OWNER_DEAD;
				end else if (own && kind_q == otmu_pkg::KIND_RECURSIVE) begin
					if (&count_q) begin
						status_d = otmu_pkg::ST_AGAIN;
					end else begin
						count_d  = count_q + otmu_pkg::count_t'(1);
						status_d = otmu_pkg::ST_OK;
					end
				end else if (own && kind_q == otmu_pkg::KIND_ERRCHECK) begin
					status_d = is_try ? otmu_pkg::ST_BUSY : otmu_pkg::ST_DEADLOCK;
				end else if (!held) begin
					lock_state_d = otmu_pkg::LS_HELD;
					owner_d      = tid_s1;
					count_d      = otmu_pkg::count_t'(1);
					status_d     = otmu_pkg::ST_OK;
				end else if (is_try) begin
					status_d = otmu_pkg::ST_BUSY;
				end else begin
					lock_state_d = otmu_pkg::LS_WAITERS;
					status_d     = otmu_pkg::ST_WAIT;
				end
			end
			otmu_pkg::ACT_UNLOCK: begin
				priority if (!held) begin
					status_d = otmu_pkg::ST_NOT_OWNER;
				end else if ((kind_q == otmu_pkg::KIND_RECURSIVE ||
					kind_q == otmu_pkg::KIND_ERRCHECK) && !own) begin
					status_d = otmu_pkg::ST_NOT_OWNER;
				end else if (kind_q == otmu_pkg::KIND_RECURSIVE &&
					count_q > otmu_pkg::count_t'(1)) begin
					count_d  = count_q - otmu_pkg::count_t'(1);
					status_d = otmu_pkg::ST_OK;
				end else begin
					wake_d       = lock_state_q == otmu_pkg::LS_WAITERS;
					lock_state_d = otmu_pkg::LS_FREE;
					owner_d      = '0;
					count_d      = '0;
					dead_d       = 1'b0;
					incons_d     = 1'b0;
					status_d     = otmu_pkg::ST_OK;
				end
			end
			otmu_pkg::ACT_CONSISTENT: begin
				priority if (!robust_q || !incons_q) begin
					status_d = otmu_pkg::ST_INVALID;
				end else if (!own) begin
					status_d = otmu_pkg::ST_NOT_OWNER;
				end else begin
					incons_d = 1'b0;
					status_d = otmu_pkg::ST_OK;
				end
			end
			otmu_pkg::ACT_DESTROY: begin
				status_d = held ? otmu_pkg::ST_BUSY : otmu_pkg::ST_OK;
			end
			otmu_pkg::ACT_OWNER_DIED: begin
				priority if (!robust_q || !held) begin
					status_d = otmu_pkg::ST_INVALID;
				end else if (!own) begin
					status_d = otmu_pkg::ST_NOT_OWNER;
				end else begin
					dead_d   = 1'b1;
					status_d = otmu_pkg::ST_OK;
				end
			end
			default: begin
				status_d = otmu_pkg::ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_state_q <= otmu_pkg::LS_FREE;
			owner_q      <= '0;
			count_q      <= '0;
			dead_q       <= 1'b0;
			incons_q     <= 1'b0;
		end else if (adv_s1) begin
			lock_state_q <= lock_state_d;
			owner_q      <= owner_d;
			count_q      <= count_d;
			dead_q       <= dead_d;
			incons_q     <= incons_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_s1 <= req.action;
			tid_s1 <= req.thread_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_d;
			wake_s2   <= wake_d;
			held_s2   <= lock_state_d != otmu_pkg::LS_FREE;
			owner_s2  <= owner_d;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.status    = status_s2;
	assign rsp.wake_one  = wake_s2;
	assign rsp.held      = held_s2;
	assign rsp.owner_now = owner_s2;

	// a free mutex carries no owner, count or recovery flags
	a_free_clean: assert property (@(posedge clk) disable iff (!arst_n)
		lock_state_q == otmu_pkg::LS_FREE |->
			(owner_q == '0 && count_q == '0 && !dead_q && !incons_q))
		else $error("free mutex with stale owner state");

	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		lock_state_q != otmu_pkg::LS_FREE |-> count_q != '0)
		else $error("held mutex with zero hold count");

	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && wake_s2 |-> (status_s2 == otmu_pkg::ST_OK && !held_s2))
		else $error("wake_one without a successful release");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(lock_state_q) && $stable(owner_q) && $stable(count_q)))
		else $error("mutex state changed without a transaction");

endmodule

`default_nettype wire
